### src/lobm_pkg.sv
package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 32;
    localparam int MAX_TRADES      = 32;

    localparam logic       CMD_SUBMIT = 1'b0;
    localparam logic       CMD_CANCEL = 1'b1;
    localparam logic       KIND_TRADE  = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OPEN      = 3'd0;
    localparam logic [2:0] ST_PARTIAL   = 3'd1;
    localparam logic [2:0] ST_FILLED    = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_FILL,
        S_TRADE,
        S_REST,
        S_BEST,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic        cmd;
        logic        side;
        logic        mkt;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] user;
        logic [31:0] cid;
    } t_cmd;

    typedef struct packed {
        logic        kind;
        logic        last;
        logic [31:0] trade_id;
        logic [31:0] taker_order_id;
        logic [31:0] maker_order_id;
        logic [31:0] trade_user;
        logic        taker_side;
        logic [31:0] fill_price;
        logic [31:0] exec_qty;
        logic [2:0]  status;
        logic [31:0] top_bid;
        logic [31:0] top_ask;
    } t_res;

endpackage

### src/lobm_if.sv
interface lobm_cmd_if
    import lobm_pkg::*;
();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lobm_res_if
    import lobm_pkg::*;
();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/limit_order_book_matcher.sv
// Single-symbol limit order book, price-time priority, one command at a time.
// The slot table is walked one slot per cycle with one shared compare unit. A cancel
// is a search pass, a best-price pass and a status step. A submit spends a search, a
// read, a fill and a transfer step per trade; when not filled, a last search plus read
// (skipped once MAX_TRADES trades are done), a free-slot pass for a limit remainder,
// and the best-price pass plus the status step follow. A zero-quantity submit goes
// straight to the best-price pass. Results leave through one output register; a
// stalled result holds the block, and i_cmd.ready is high only between commands.
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lobm_cmd_if.sink      i_cmd,
    lobm_res_if.source    o_res
);
    localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int TW = $clog2(MAX_TRADES + 1);

    logic [ORDER_SLOTS-1:0] r_valid;
    logic [ORDER_SLOTS-1:0] r_sell;
    logic [31:0] m_price  [ORDER_SLOTS];
    logic [31:0] m_rem    [ORDER_SLOTS];
    logic [31:0] m_oid    [ORDER_SLOTS];

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [31:0] r_oid_ctr, r_tid_ctr, r_id, r_left, r_fill;
    logic [CW-1:0] r_idx;
    logic [TW-1:0] r_ntr;
    logic        r_has, r_hb, r_ha, r_found;
    logic [IW-1:0] r_best;
    logic [31:0] r_bpx, r_bid_id, r_bb, r_ba;
    logic [31:0] r_rd_rem;
    logic [31:0] r_mp, r_mo;
    logic        r_pv;
    logic [IW-1:0] r_pi;
    logic [2:0]  r_st;
    logic        r_ov;
    t_res        r_out;

    logic          w_scan, w_issue, w_last, w_load;
    logic [31:0]   w_fill;
    logic          w_elig, w_better;

    assign w_scan  = r_state inside {S_SCAN, S_REST, S_BEST};
    assign w_issue = w_scan && (r_idx != CW'(ORDER_SLOTS));
    assign w_last  = r_pv && (r_pi == IW'(ORDER_SLOTS - 1));
    assign w_load  = (r_state inside {S_TRADE, S_STATUS}) && (!r_ov || o_res.ready);
    assign w_fill  = (r_left < r_rd_rem) ? r_left : r_rd_rem;

    // slot read pipeline: r_mp/r_mo hold slot r_pi when r_pv
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_mp <= m_price[r_idx[IW-1:0]];
            r_mo <= m_oid[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_pv  <= 1'b0;
            r_pi  <= '0;
        end else if (n_state != r_state) begin
            r_idx <= '0;
            r_pv  <= 1'b0;
        end else if (w_issue) begin
            r_idx <= r_idx + CW'(1);
            r_pv  <= 1'b1;
            r_pi  <= r_idx[IW-1:0];
        end else begin
            r_pv  <= 1'b0;
        end
    end

    always_comb begin
        w_elig = r_pv && r_valid[r_pi] && (r_sell[r_pi] != r_cmd.side) &&
                 (r_cmd.mkt ||
                  (r_cmd.side ? (r_mp >= r_cmd.price) : (r_mp <= r_cmd.price)));
        if (!r_has)
            w_better = 1'b1;
        else if (r_mp == r_bpx)
            w_better = r_mo < r_bid_id;
        else
            w_better = r_cmd.side ? (r_mp > r_bpx) : (r_mp < r_bpx);
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.data.cmd == CMD_CANCEL) n_state = S_SCAN;
                    else if (i_cmd.data.qty == 32'd0) n_state = S_BEST;
                    else n_state = S_SCAN;
                end
            end
            S_SCAN: if (w_last) n_state = (r_cmd.cmd == CMD_CANCEL) ? S_BEST : S_RD;
            S_RD: begin
                if (!r_has) n_state = r_cmd.mkt ? S_BEST : S_REST;
                else n_state = S_FILL;
            end
            S_FILL:  n_state = S_TRADE;
            S_TRADE: begin
                if (w_load) begin
                    if (r_left == 32'd0) n_state = S_BEST;
                    else if (r_ntr == TW'(MAX_TRADES))
                        n_state = r_cmd.mkt ? S_BEST : S_REST;
                    else n_state = S_SCAN;
                end
            end
            S_REST: if (r_pv && (!r_valid[r_pi] || w_last)) n_state = S_BEST;
            S_BEST: if (w_last) n_state = S_STATUS;
            S_STATUS: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_oid_ctr <= '0;
            r_tid_ctr <= '0;
            r_ntr     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.data;
                        r_has   <= 1'b0;
                        r_found <= 1'b0;
                        r_ntr   <= '0;
                        r_left  <= i_cmd.data.qty;
                        r_hb    <= 1'b0;
                        r_ha    <= 1'b0;
                        r_bb    <= '0;
                        r_ba    <= '0;
                        r_st    <= ST_REJECTED;
                        if (i_cmd.data.cmd == CMD_CANCEL) begin
                            r_id <= i_cmd.data.cid;
                        end else begin
                            r_id      <= r_oid_ctr + 32'd1;
                            r_oid_ctr <= r_oid_ctr + 32'd1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        if (r_cmd.cmd == CMD_CANCEL) begin
                            if (!r_found && r_valid[r_pi] && (r_mo == r_cmd.cid)) begin
                                r_found <= 1'b1;
                                r_valid[r_pi] <= 1'b0;
                                r_st <= ST_CANCELLED;
                            end
                        end else if (w_elig && w_better) begin
                            r_has    <= 1'b1;
                            r_best   <= r_pi;
                            r_bpx    <= r_mp;
                            r_bid_id <= r_mo;
                        end
                    end
                end
                S_RD: begin
                    r_rd_rem <= m_rem[r_best];
                end
                S_FILL: begin
                    r_tid_ctr <= r_tid_ctr + 32'd1;
                    r_fill    <= w_fill;
                    r_left    <= r_left - w_fill;
                    if (r_rd_rem == w_fill) r_valid[r_best] <= 1'b0;
                    r_ntr <= r_ntr + TW'(1);
                end
                S_TRADE: begin
                    if (w_load) begin
                        r_out.kind           <= KIND_TRADE;
                        r_out.last           <= 1'b0;
                        r_out.trade_id       <= r_tid_ctr;
                        r_out.taker_order_id <= r_id;
                        r_out.maker_order_id <= r_bid_id;
                        r_out.trade_user     <= r_cmd.user;
                        r_out.taker_side     <= r_cmd.side;
                        r_out.fill_price     <= r_bpx;
                        r_out.exec_qty       <= r_fill;
                        r_out.status         <= ST_OPEN;
                        r_out.top_bid        <= '0;
                        r_out.top_ask        <= '0;
                        r_has <= 1'b0;
                        if (r_left == 32'd0) r_st <= ST_FILLED;
                        else if (r_cmd.mkt) r_st <= ST_PARTIAL;
                    end
                end
                S_REST: begin
                    if (r_pv) begin
                        if (!r_valid[r_pi]) begin
                            r_valid[r_pi] <= 1'b1;
                            r_sell[r_pi]  <= r_cmd.side;
                            r_st <= (r_left < r_cmd.qty) ? ST_PARTIAL : ST_OPEN;
                        end else if (w_last) begin
                            r_st <= ST_REJECTED;
                        end
                    end
                end
                S_BEST: begin
                    if (r_pv && r_valid[r_pi]) begin
                        if (r_sell[r_pi]) begin
                            if (!r_ha || r_mp < r_ba) begin
                                r_ba <= r_mp;
                                r_ha <= 1'b1;
                            end
                        end else if (!r_hb || r_mp > r_bb) begin
                            r_bb <= r_mp;
                            r_hb <= 1'b1;
                        end
                    end
                end
                S_STATUS: begin
                    if (w_load) begin
                        r_out.kind           <= KIND_STATUS;
                        r_out.last           <= 1'b1;
                        r_out.trade_id       <= '0;
                        r_out.taker_order_id <= r_id;
                        r_out.maker_order_id <= '0;
                        r_out.trade_user     <= '0;
                        r_out.taker_side     <= r_cmd.side;
                        r_out.fill_price     <= '0;
                        r_out.exec_qty       <= '0;
                        r_out.status         <= r_st;
                        r_out.top_bid        <= r_bb;
                        r_out.top_ask        <= r_ba;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) m_rem[r_best] <= r_rd_rem - w_fill;
        if ((r_state == S_REST) && r_pv && !r_valid[r_pi]) begin
            m_price[r_pi] <= r_cmd.price;
            m_rem[r_pi]   <= r_left;
            m_oid[r_pi]   <= r_id;
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.kind == KIND_TRADE) |-> o_res.data.exec_qty != 32'd0)
        else $error("zero fill");
    a_trade_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ntr <= TW'(MAX_TRADES)) else $error("trade cap exceeded");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.last == o_res.data.kind)) else $error("last mismatch");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.data)))
        else $error("result changed while waiting");
`endif

endmodule
